// ===== hw/rtl/imp_pkg.sv =====
// ----------------------------------------------------------------------------
// Indirect memory prefetcher package
// Shared constants, codes, record types and helper functions.
// ----------------------------------------------------------------------------
package imp_pkg;

  localparam int TBL_N     = 16;
  localparam int TBL_W     = (TBL_N > 1) ? $clog2(TBL_N) : 1;
  localparam int DET_N     = 4;
  localparam int DET_W     = (DET_N > 1) ? $clog2(DET_N) : 1;
  localparam int MISS_N    = 4;
  localparam int MISS_W    = (MISS_N > 1) ? $clog2(MISS_N) : 1;
  localparam int CNT_W     = $clog2(MISS_N + 1);
  localparam int LINE_BITS = 6;
  localparam int NSHIFT    = 4;
  localparam int ADDR_W    = 40;
  localparam int TAG_W     = 4;
  localparam int CROW_W    = DET_W + MISS_W;
  localparam int CAND_ROWS = 2 ** CROW_W;

  localparam logic [2:0] CONF_MAX    = 3'd7;
  localparam logic [2:0] STREAM_MAX  = 3'd4;
  localparam logic [4:0] DIST_MAX    = 5'd16;
  localparam logic [1:0] SHIFT_DOWN  = 2'd3;
  localparam int unsigned SHIFT_AMT [NSHIFT] = '{2, 3, 4, 3};

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_REPLY  = 1'b1;

  localparam logic [1:0] KIND_STREAM   = 2'd0;
  localparam logic [1:0] KIND_INDEX    = 2'd1;
  localparam logic [1:0] KIND_INDIRECT = 2'd2;

  localparam logic [1:0] SZ_BYTE   = 2'd0;
  localparam logic [1:0] SZ_HALF   = 2'd1;
  localparam logic [1:0] SZ_WORD   = 2'd2;
  localparam logic [1:0] SZ_DOUBLE = 2'd3;

  localparam logic [2:0] CFG_FEED_THR   = 3'd0;
  localparam logic [2:0] CFG_SPF_THR    = 3'd1;
  localparam logic [2:0] CFG_IND_THR    = 3'd2;
  localparam logic [2:0] CFG_MAX_DIST   = 3'd3;
  localparam logic [2:0] CFG_STREAM_DST = 3'd4;
  localparam logic [2:0] CFG_BO_UNIT    = 3'd5;
  localparam logic [2:0] CFG_BO_CAP     = 3'd6;

  typedef struct packed {
    logic [2:0]  feed_thr;
    logic [2:0]  spf_thr;
    logic [2:0]  ind_thr;
    logic [4:0]  max_dist;
    logic [2:0]  stream_dist;
    logic [15:0] bo_unit;
    logic [3:0]  bo_cap;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [63:0] addr;
    logic [63:0] pc;
    logic        hit;
    logic [63:0] now;
    logic [63:0] data;
    logic [3:0]  rep;
  } in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        size;
    logic [TAG_W-1:0]  tag;
  } res_t;

  typedef struct packed {
    logic push;
    logic flush;
    res_t res;
  } push_t;

  typedef struct packed {
    logic [63:0] pc;
    logic [63:0] last_addr;
    logic [63:0] stride;
    logic [2:0]  conf;
    logic        ind_on;
    logic [1:0]  shift;
    logic [63:0] base;
    logic [2:0]  iconf;
    logic [63:0] pidx;
    logic        pvalid;
    logic        pf_on;
    logic [4:0]  pdist;
    logic [63:0] last_used;
    logic [3:0]  bexp;
    logic [63:0] buntil;
  } ent_t;

  typedef logic [NSHIFT-1:0][63:0] cand_row_t;

  function automatic logic [63:0] scaled(input logic [63:0] idx, input logic [1:0] s);
    logic [63:0] r;
    if (s == SHIFT_DOWN) r = idx >> SHIFT_AMT[s];
    else r = idx << SHIFT_AMT[s];
    return r;
  endfunction

  function automatic logic addr_ok(input logic [63:0] a);
    return (a != 64'd0) && (a[63:ADDR_W] == '0);
  endfunction

  function automatic logic [1:0] size_code(input logic [63:0] stride);
    logic [1:0] c;
    if (stride == 64'd1 || stride == 64'hffff_ffff_ffff_ffff) c = SZ_BYTE;
    else if (stride == 64'd2 || stride == 64'hffff_ffff_ffff_fffe) c = SZ_HALF;
    else if (stride == 64'd8 || stride == 64'hffff_ffff_ffff_fff8) c = SZ_DOUBLE;
    else c = SZ_WORD;
    return c;
  endfunction

  function automatic logic [63:0] cut_size(input logic [63:0] v, input logic [1:0] code);
    logic [63:0] r;
    case (code)
      SZ_BYTE: r = {56'd0, v[7:0]};
      SZ_HALF: r = {48'd0, v[15:0]};
      SZ_WORD: r = {32'd0, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/imp_cfg.sv =====
// ----------------------------------------------------------------------------
// Indirect memory prefetcher configuration registers
// Holds the seven control registers written through the configuration port.
// ----------------------------------------------------------------------------
module imp_cfg import imp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.feed_thr    <= 3'd2;
      cfg.spf_thr     <= 3'd4;
      cfg.ind_thr     <= 3'd2;
      cfg.max_dist    <= 5'd16;
      cfg.stream_dist <= 3'd4;
      cfg.bo_unit     <= 16'd100;
      cfg.bo_cap      <= 4'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FEED_THR:   cfg.feed_thr    <= cfg_data[2:0];
        CFG_SPF_THR:    cfg.spf_thr     <= cfg_data[2:0];
        CFG_IND_THR:    cfg.ind_thr     <= cfg_data[2:0];
        CFG_MAX_DIST:   cfg.max_dist    <= cfg_data[4:0];
        CFG_STREAM_DST: cfg.stream_dist <= cfg_data[2:0];
        CFG_BO_UNIT:    cfg.bo_unit     <= cfg_data;
        CFG_BO_CAP:     cfg.bo_cap      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/imp_out.sv =====
// ----------------------------------------------------------------------------
// Indirect memory prefetcher result stage
// One hold register marks the final result; an output register drives the bus.
// ----------------------------------------------------------------------------
module imp_out import imp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  push_t       pq,
  output logic        stage_rdy,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_addr, read_size, entry_tag, zero pad
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast
);

  logic hold_v;
  res_t hold;
  res_t obuf;
  logic out_free;
  logic load;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign stage_rdy = !hold_v || out_free;
  assign load      = stage_rdy && hold_v && (pq.push || pq.flush);

  assign m_axis_tdata = {2'd0, obuf.tag, obuf.size, obuf.addr};
  assign m_axis_tuser = obuf.kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load) begin
        obuf          <= hold;
        m_axis_tlast  <= !pq.push;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (pq.push && stage_rdy) begin
        hold   <= pq.res;
        hold_v <= 1'b1;
      end else if (pq.flush && stage_rdy) begin
        hold_v <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/imp_core.sv =====
// ----------------------------------------------------------------------------
// Indirect memory prefetcher core
// Sequencer around the stream table memory and the detector candidate memory.
// ----------------------------------------------------------------------------
module imp_core import imp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  in_t   in_item,
  input  cfg_t  cfg,
  input  logic  stage_rdy,
  output push_t pq
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SWEEP  = 4'd1;
  localparam logic [3:0] S_UPD    = 4'd2;
  localparam logic [3:0] S_SPF    = 4'd3;
  localparam logic [3:0] S_IDXPF  = 4'd4;
  localparam logic [3:0] S_FEED   = 4'd5;
  localparam logic [3:0] S_WB     = 4'd6;
  localparam logic [3:0] S_ALLOC  = 4'd7;
  localparam logic [3:0] S_FLUSH  = 4'd8;
  localparam logic [3:0] S_MD     = 4'd9;
  localparam logic [3:0] S_MCMP   = 4'd10;
  localparam logic [3:0] S_MRES   = 4'd11;
  localparam logic [3:0] S_MAPPLY = 4'd12;
  localparam logic [3:0] S_RRD    = 4'd13;
  localparam logic [3:0] S_RCALC  = 4'd14;

  localparam int SW_W = $clog2(TBL_N + 2);
  localparam int DC_W = $clog2(DET_N + 1);

  logic [3:0] state;
  in_t        it;

  ent_t tbl_mem [TBL_N];
  ent_t tbl_rd, tbl_wd;
  logic tbl_we;
  logic [TBL_W-1:0] tbl_wa, tbl_ra;
  logic [TBL_N-1:0] tbl_valid;

  cand_row_t cand_mem [CAND_ROWS];
  cand_row_t cand_rd, cand_wd;
  logic cand_we;
  logic [CROW_W-1:0] cand_wa, cand_ra;

  logic [DET_N-1:0] det_valid;
  logic [DET_N-1:0] det_has2;
  logic [TBL_W-1:0] det_owner  [DET_N];
  logic [63:0]      det_first  [DET_N];
  logic [63:0]      det_second [DET_N];
  logic [CNT_W-1:0] det_cnt1   [DET_N];
  logic [CNT_W-1:0] det_cnt2   [DET_N];

  logic [SW_W-1:0]  k;
  logic             found, inv_found, has1, has2;
  logic [TBL_W-1:0] e, inv_idx, best1, best2;
  logic [63:0]      low1, low2;
  ent_t             cur;
  logic [4:0]       cnt;
  logic [63:0]      run_addr;
  logic [DC_W-1:0]  dcnt;
  logic [MISS_W-1:0] m;
  logic [63:0]      b2 [NSHIFT];
  logic [NSHIFT-1:0] hits;

  logic             sw_proc;
  logic [TBL_W-1:0] sw_j;
  logic [63:0]      ver_exp;
  logic             ver_hit;
  logic [2:0]       iconf_inc;
  ent_t             w_upd;
  logic [TBL_W-1:0] victim;
  ent_t             alloc_word;
  logic [63:0]      ns;
  ent_t             upd;
  logic [2:0]       spf_lim;
  logic [4:0]       idx_lim, md;
  logic             spf_go, idx_go, run_ok;
  logic [1:0]       sc;
  logic [63:0]      idx;
  logic             f_hit, fr_hit;
  logic [DET_W-1:0] f_d, fr_d, d;
  logic [63:0]      bo_wait;
  logic             md_write;
  logic [NSHIFT-1:0] cmp;
  logic [1:0]       hit_s;
  ent_t             ap_word;
  logic [TBL_W-1:0] r_idx;
  logic             r_ok;
  logic [63:0]      r_addr;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    tbl_rd <= tbl_mem[tbl_ra];
  end

  always_ff @(posedge clk) begin
    if (cand_we) cand_mem[cand_wa] <= cand_wd;
    cand_rd <= cand_mem[cand_ra];
  end

  always_comb begin
    sw_proc   = (k != '0) && (k <= SW_W'(TBL_N));
    sw_j      = TBL_W'(k - SW_W'(1));
    ver_exp   = scaled(tbl_rd.pidx, tbl_rd.shift) + tbl_rd.base;
    ver_hit   = tbl_rd.ind_on && !tbl_rd.pf_on && tbl_rd.pvalid &&
                (it.addr[63:LINE_BITS] == ver_exp[63:LINE_BITS]);
    iconf_inc = (tbl_rd.iconf < CONF_MAX) ? tbl_rd.iconf + 3'd1 : tbl_rd.iconf;
    w_upd     = tbl_rd;
    if (ver_hit) begin
      w_upd.iconf  = iconf_inc;
      w_upd.pvalid = 1'b0;
      if (iconf_inc >= cfg.ind_thr) w_upd.pf_on = 1'b1;
    end

    if (inv_found) victim = inv_idx;
    else if (has1) victim = best1;
    else if (has2) victim = best2;
    else victim = '0;

    alloc_word           = '0;
    alloc_word.pc        = it.pc;
    alloc_word.last_addr = it.addr;
    alloc_word.last_used = it.now;
    alloc_word.pdist     = 5'd1;

    ns  = it.addr - cur.last_addr;
    upd = cur;
    upd.last_used = it.now;
    if (ns != 64'd0) begin
      if (ns == cur.stride && cur.conf != 3'd0) begin
        if (cur.conf < CONF_MAX) upd.conf = cur.conf + 3'd1;
      end else if (cur.conf <= 3'd1) begin
        upd.stride = ns;
        upd.conf   = 3'd1;
      end else if (cur.ind_on) begin
        upd.stride = ns;
        upd.conf   = 3'd1;
        upd.pdist  = 5'd1;
      end else begin
        upd.conf   = cur.conf - 3'd1;
        upd.stride = ns;
      end
      upd.last_addr = it.addr;
    end

    spf_lim = (cfg.stream_dist > STREAM_MAX) ? STREAM_MAX : cfg.stream_dist;
    idx_lim = (cur.pdist > DIST_MAX) ? DIST_MAX : cur.pdist;
    if (cfg.max_dist == 5'd0) md = 5'd1;
    else if (cfg.max_dist > DIST_MAX) md = DIST_MAX;
    else md = cfg.max_dist;
    spf_go  = (cur.conf >= cfg.spf_thr) && (cnt <= {2'd0, spf_lim});
    idx_go  = (cnt <= idx_lim);
    run_ok  = addr_ok(run_addr);
    sc      = size_code(cur.stride);
    idx     = cut_size(it.data, sc);
    bo_wait = 64'(cfg.bo_unit) << cur.bexp;

    f_hit  = 1'b0;
    f_d    = '0;
    fr_hit = 1'b0;
    fr_d   = '0;
    for (int i = 0; i < DET_N; i++) begin
      if (!f_hit && det_valid[i] && det_owner[i] == e) begin
        f_hit = 1'b1;
        f_d   = DET_W'(i);
      end
      if (!fr_hit && !det_valid[i]) begin
        fr_hit = 1'b1;
        fr_d   = DET_W'(i);
      end
    end

    d        = DET_W'(dcnt);
    md_write = (dcnt != DC_W'(DET_N)) && det_valid[d] && !det_has2[d] &&
               (det_cnt1[d] < CNT_W'(MISS_N));
    for (int s = 0; s < NSHIFT; s++) begin
      cand_wd[s] = it.addr - scaled(det_first[d], 2'(s));
      cmp[s]     = (cand_rd[s] == b2[s]);
    end
    hit_s = '0;
    for (int s = NSHIFT - 1; s >= 0; s--) begin
      if (hits[s]) hit_s = 2'(s);
    end

    ap_word        = tbl_rd;
    ap_word.ind_on = 1'b1;
    ap_word.shift  = hit_s;
    ap_word.base   = b2[hit_s];
    ap_word.iconf  = 3'd0;
    ap_word.pvalid = 1'b0;
    ap_word.pf_on  = 1'b0;
    ap_word.pdist  = 5'd1;
    ap_word.bexp   = 4'd0;
    ap_word.buntil = 64'd0;

    r_idx  = TBL_W'(it.rep);
    r_ok   = (32'(it.rep) < TBL_N) && tbl_valid[r_idx] && tbl_rd.ind_on;
    r_addr = scaled(cut_size(it.data, size_code(tbl_rd.stride)), tbl_rd.shift) +
             tbl_rd.base;
  end

  always_comb begin
    tbl_ra  = TBL_W'(k);
    tbl_we  = 1'b0;
    tbl_wa  = e;
    tbl_wd  = cur;
    cand_we = 1'b0;
    cand_wa = {d, MISS_W'(det_cnt1[d])};
    cand_ra = {d, MISS_W'(0)};
    pq      = '0;
    unique case (state)
      S_SWEEP: begin
        if (sw_proc && tbl_valid[sw_j]) begin
          tbl_we = 1'b1;
          tbl_wa = sw_j;
          tbl_wd = w_upd;
        end
      end
      S_SPF: begin
        if (cnt != 5'd0 && spf_go && run_ok) begin
          pq.push     = stage_rdy;
          pq.res.kind = KIND_STREAM;
          pq.res.addr = run_addr[ADDR_W-1:0];
        end
      end
      S_IDXPF: begin
        if (cnt != 5'd0 && idx_go && run_ok) begin
          pq.push     = stage_rdy;
          pq.res.kind = KIND_INDEX;
          pq.res.addr = run_addr[ADDR_W-1:0];
          pq.res.size = sc;
          pq.res.tag  = TAG_W'(e);
        end
      end
      S_WB: tbl_we = 1'b1;
      S_ALLOC: begin
        tbl_we = 1'b1;
        tbl_wa = victim;
        tbl_wd = alloc_word;
      end
      S_FLUSH: pq.flush = 1'b1;
      S_MD: cand_we = md_write;
      S_MCMP: cand_ra = {d, MISS_W'(m + MISS_W'(1))};
      S_MRES: tbl_ra = det_owner[d];
      S_MAPPLY: begin
        tbl_we = 1'b1;
        tbl_wa = det_owner[d];
        tbl_wd = ap_word;
      end
      S_RRD: tbl_ra = r_idx;
      S_RCALC: begin
        tbl_ra = r_idx;
        if (r_ok && addr_ok(r_addr)) begin
          pq.push     = stage_rdy;
          pq.res.kind = KIND_INDIRECT;
          pq.res.addr = r_addr[ADDR_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tbl_valid <= '0;
      det_valid <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            it        <= in_item;
            k         <= '0;
            found     <= 1'b0;
            inv_found <= 1'b0;
            has1      <= 1'b0;
            has2      <= 1'b0;
            low1      <= '1;
            low2      <= '1;
            state     <= (in_item.op == OP_REPLY) ? S_RRD : S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (sw_proc && tbl_valid[sw_j]) begin
            if (!found && tbl_rd.pc == it.pc) begin
              found <= 1'b1;
              e     <= sw_j;
              cur   <= w_upd;
            end
            if (!w_upd.pf_on && tbl_rd.last_used < low1) begin
              has1  <= 1'b1;
              best1 <= sw_j;
              low1  <= tbl_rd.last_used;
            end
            if (tbl_rd.last_used < low2) begin
              has2  <= 1'b1;
              best2 <= sw_j;
              low2  <= tbl_rd.last_used;
            end
          end else if (sw_proc && !inv_found) begin
            inv_found <= 1'b1;
            inv_idx   <= sw_j;
          end
          if (k == SW_W'(TBL_N + 1)) state <= found ? S_UPD : S_ALLOC;
          else k <= k + SW_W'(1);
        end
        S_UPD: begin
          cur   <= upd;
          cnt   <= 5'd0;
          state <= (ns != 64'd0) ? S_SPF : S_WB;
        end
        S_SPF: begin
          if (cnt == 5'd0) begin
            run_addr <= it.addr + cur.stride;
            cnt      <= 5'd1;
          end else if (spf_go) begin
            if (!run_ok || stage_rdy) begin
              run_addr <= run_addr + cur.stride;
              cnt      <= cnt + 5'd1;
            end
          end else begin
            cnt <= 5'd0;
            if (cur.conf >= cfg.feed_thr)
              state <= (cur.ind_on && cur.pf_on) ? S_IDXPF : S_FEED;
            else
              state <= S_WB;
          end
        end
        S_IDXPF: begin
          if (cnt == 5'd0) begin
            run_addr <= it.addr + cur.stride;
            cnt      <= 5'd1;
          end else if (idx_go) begin
            if (!run_ok || stage_rdy) begin
              run_addr <= run_addr + cur.stride;
              cnt      <= cnt + 5'd1;
            end
          end else begin
            if (cur.pdist < md) cur.pdist <= cur.pdist + 5'd1;
            state <= S_WB;
          end
        end
        S_FEED: begin
          if (cur.ind_on) begin
            if (cur.pvalid && cur.iconf != 3'd0) cur.iconf <= cur.iconf - 3'd1;
            cur.pidx   <= idx;
            cur.pvalid <= 1'b1;
          end else if (it.now >= cur.buntil) begin
            if (!f_hit) begin
              if (fr_hit) begin
                det_valid[fr_d]  <= 1'b1;
                det_owner[fr_d]  <= e;
                det_first[fr_d]  <= idx;
                det_second[fr_d] <= 64'd0;
                det_has2[fr_d]   <= 1'b0;
                det_cnt1[fr_d]   <= '0;
                det_cnt2[fr_d]   <= '0;
              end
            end else if (!det_has2[f_d]) begin
              det_second[f_d] <= idx;
              det_has2[f_d]   <= 1'b1;
              det_cnt2[f_d]   <= '0;
            end else begin
              det_valid[f_d] <= 1'b0;
              if (cur.bexp < cfg.bo_cap) cur.bexp <= cur.bexp + 4'd1;
              cur.buntil <= it.now + bo_wait;
            end
          end
          state <= S_WB;
        end
        S_WB: state <= S_FLUSH;
        S_ALLOC: begin
          tbl_valid[victim] <= 1'b1;
          for (int i = 0; i < DET_N; i++) begin
            if (det_valid[i] && det_owner[i] == victim) det_valid[i] <= 1'b0;
          end
          state <= S_FLUSH;
        end
        S_FLUSH: begin
          if (stage_rdy) begin
            dcnt  <= '0;
            state <= (it.op == OP_ACCESS && !it.hit) ? S_MD : S_IDLE;
          end
        end
        S_MD: begin
          if (dcnt == DC_W'(DET_N)) begin
            state <= S_IDLE;
          end else if (!det_valid[d]) begin
            dcnt <= dcnt + DC_W'(1);
          end else if (!det_has2[d]) begin
            if (md_write) det_cnt1[d] <= det_cnt1[d] + CNT_W'(1);
            dcnt <= dcnt + DC_W'(1);
          end else if (det_cnt2[d] < CNT_W'(MISS_N)) begin
            for (int s = 0; s < NSHIFT; s++) begin
              b2[s] <= it.addr - scaled(det_second[d], 2'(s));
            end
            hits <= '0;
            m    <= '0;
            if (det_cnt1[d] == '0) begin
              det_cnt2[d] <= det_cnt2[d] + CNT_W'(1);
              dcnt        <= dcnt + DC_W'(1);
            end else begin
              state <= S_MCMP;
            end
          end else begin
            dcnt <= dcnt + DC_W'(1);
          end
        end
        S_MCMP: begin
          hits <= hits | cmp;
          if (CNT_W'(m) + CNT_W'(1) < det_cnt1[d]) m <= m + MISS_W'(1);
          else state <= S_MRES;
        end
        S_MRES: begin
          if (hits != '0) begin
            det_valid[d] <= 1'b0;
            state        <= S_MAPPLY;
          end else begin
            det_cnt2[d] <= det_cnt2[d] + CNT_W'(1);
            dcnt        <= dcnt + DC_W'(1);
            state       <= S_MD;
          end
        end
        S_MAPPLY: state <= S_IDLE;
        S_RRD: state <= S_RCALC;
        S_RCALC: begin
          if (!(r_ok && addr_ok(r_addr)) || stage_rdy) state <= S_FLUSH;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/indirect_memory_prefetcher.sv =====
// ----------------------------------------------------------------------------
// Indirect memory prefetcher
// Learns index streams and indirect patterns from cache accesses and issues
// stream prefetches, index read requests and indirect prefetches.
//
// The slave stream takes one access or index reply per transfer; tuser holds
// the operation. The master stream returns zero to twenty results per input,
// with tlast on the final one of each input. The configuration channel writes
// one of seven registers per transfer and is always ready.
// An access reads all sixteen table entries through one memory port and writes
// back the valid ones, then updates its entry and issues its results, and on a
// miss walks the four detectors, one candidate row per cycle. A reply reads its
// table entry and issues at most one indirect prefetch.
// The next input is taken once the previous one is done, even while its last
// result still waits on the master side. When the receiver stalls, results
// wait in the hold and output registers and the sequencer pauses.
// Reset clears the valid bits of the table and detectors and loads the
// register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module indirect_memory_prefetcher import imp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [263:0] s_axis_tdata,  // addr, pc, hit, cycle_now,
                                      // loaded_data, reply_entry, zero pad
  input  logic         s_axis_tuser,  // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,  // out_addr, read_size, entry_tag, zero pad
  output logic [1:0]   m_axis_tuser,  // kind
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  cfg_t  cfg;
  in_t   in_item;
  push_t pq;
  logic  stage_rdy;

  assign in_item.op   = s_axis_tuser;
  assign in_item.addr = s_axis_tdata[63:0];
  assign in_item.pc   = s_axis_tdata[127:64];
  assign in_item.hit  = s_axis_tdata[128];
  assign in_item.now  = s_axis_tdata[192:129];
  assign in_item.data = s_axis_tdata[256:193];
  assign in_item.rep  = s_axis_tdata[260:257];

  imp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  imp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .cfg       (cfg),
    .stage_rdy (stage_rdy),
    .pq        (pq)
  );

  imp_out u_out (
    .clk           (clk),
    .rst           (rst),
    .pq            (pq),
    .stage_rdy     (stage_rdy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== tb/imp_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indirect memory prefetcher result checker
// Watches the input, result and register channels, keeps its own copy of the
// stream table, detectors and registers, predicts the results of every input
// transfer and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module imp_result_checker import imp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [263:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [47:0]  m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output int           outstanding,
  output int           fail_count
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [39:0] addr;
    logic [1:0]  size;
    logic [3:0]  tag;
    logic        last;
  } pf_result_t;

  pf_result_t expected_q[$];
  pf_result_t burst_q[$];
  int         mismatches;

  logic [2:0]  feed_thr, spf_thr, ind_thr;
  logic [4:0]  max_dist;
  logic [2:0]  stream_dist;
  logic [15:0] bo_unit;
  logic [3:0]  bo_cap;

  logic        ent_valid [TBL_N];
  logic [63:0] ent_pc [TBL_N];
  logic [63:0] ent_last [TBL_N];
  logic [63:0] ent_stride [TBL_N];
  logic [2:0]  ent_conf [TBL_N];
  logic        ent_ind [TBL_N];
  logic [1:0]  ent_shift [TBL_N];
  logic [63:0] ent_base [TBL_N];
  logic [2:0]  ent_iconf [TBL_N];
  logic [63:0] ent_pidx [TBL_N];
  logic        ent_pvalid [TBL_N];
  logic        ent_pf [TBL_N];
  logic [4:0]  ent_dist [TBL_N];
  logic [63:0] ent_used [TBL_N];
  logic [3:0]  ent_bexp [TBL_N];
  logic [63:0] ent_buntil [TBL_N];

  logic        det_on [DET_N];
  logic [3:0]  det_ent [DET_N];
  logic [63:0] det_idx1 [DET_N];
  logic [63:0] det_idx2 [DET_N];
  logic        det_two [DET_N];
  logic [63:0] det_cand [DET_N][NSHIFT][MISS_N];
  logic [2:0]  det_cnt1 [DET_N];
  logic [2:0]  det_cnt2 [DET_N];

  function automatic logic [63:0] shift_index(logic [63:0] v, logic [1:0] s);
    case (s)
      2'd0: return v << 2;
      2'd1: return v << 3;
      2'd2: return v << 4;
      default: return v >> 3;
    endcase
  endfunction

  function automatic logic addr_good(logic [63:0] a);
    return a != 64'd0 && a[63:40] == 24'd0;
  endfunction

  function automatic logic [1:0] elem_size(logic [63:0] stride);
    logic [63:0] mag;
    mag = stride[63] ? -stride : stride;
    if (mag == 64'd1) return SZ_BYTE;
    if (mag == 64'd2) return SZ_HALF;
    if (mag == 64'd8) return SZ_DOUBLE;
    return SZ_WORD;
  endfunction

  function automatic logic [63:0] trim_index(logic [63:0] v, logic [1:0] code);
    case (code)
      SZ_BYTE: return v & 64'hff;
      SZ_HALF: return v & 64'hffff;
      SZ_WORD: return v & 64'hffff_ffff;
      default: return v;
    endcase
  endfunction

  function automatic void add_result(logic [1:0] kind, logic [63:0] a, logic [1:0] size,
                                     logic [3:0] tag);
    pf_result_t r;
    r.kind = kind;
    r.addr = a[39:0];
    r.size = size;
    r.tag  = tag;
    r.last = 1'b0;
    burst_q.push_back(r);
  endfunction

  function automatic void clear_entry(int e);
    ent_valid[e] = 0; ent_pc[e] = 0; ent_last[e] = 0; ent_stride[e] = 0;
    ent_conf[e] = 0; ent_ind[e] = 0; ent_shift[e] = 0; ent_base[e] = 0;
    ent_iconf[e] = 0; ent_pidx[e] = 0; ent_pvalid[e] = 0; ent_pf[e] = 0;
    ent_dist[e] = 1; ent_used[e] = 0; ent_bexp[e] = 0; ent_buntil[e] = 0;
  endfunction

  function automatic void clear_detector(int d);
    det_on[d] = 0; det_ent[d] = 0; det_idx1[d] = 0; det_idx2[d] = 0;
    det_two[d] = 0; det_cnt1[d] = 0; det_cnt2[d] = 0;
    for (int s = 0; s < NSHIFT; s++)
      for (int m = 0; m < MISS_N; m++) det_cand[d][s][m] = 0;
  endfunction

  function automatic void reset_prefetcher();
    feed_thr = 2; spf_thr = 4; ind_thr = 2; max_dist = 16;
    stream_dist = 4; bo_unit = 100; bo_cap = 10;
    for (int i = 0; i < TBL_N; i++) clear_entry(i);
    for (int i = 0; i < DET_N; i++) clear_detector(i);
  endfunction

  function automatic int pick_victim();
    int best;
    logic [63:0] low;
    best = -1;
    low = '1;
    for (int i = 0; i < TBL_N; i++)
      if (!ent_valid[i]) return i;
    for (int i = 0; i < TBL_N; i++)
      if (!ent_pf[i] && ent_used[i] < low) begin
        low = ent_used[i];
        best = i;
      end
    if (best >= 0) return best;
    for (int i = 0; i < TBL_N; i++)
      if (ent_used[i] < low) begin
        low = ent_used[i];
        best = i;
      end
    return best >= 0 ? best : 0;
  endfunction

  function automatic void detector_miss(logic [63:0] miss);
    logic [63:0] b2;
    int e;
    for (int d = 0; d < DET_N; d++) begin
      if (!det_on[d]) continue;
      if (!det_two[d]) begin
        if (det_cnt1[d] < MISS_N) begin
          for (int s = 0; s < NSHIFT; s++)
            det_cand[d][s][det_cnt1[d]] = miss - shift_index(det_idx1[d], 2'(s));
          det_cnt1[d]++;
        end
      end else if (det_cnt2[d] < MISS_N) begin
        for (int s = 0; s < NSHIFT; s++) begin
          b2 = miss - shift_index(det_idx2[d], 2'(s));
          for (int m = 0; m < det_cnt1[d] && m < MISS_N; m++) begin
            if (b2 == det_cand[d][s][m]) begin
              e = det_ent[d];
              ent_ind[e] = 1; ent_shift[e] = 2'(s); ent_base[e] = b2;
              ent_iconf[e] = 0; ent_pvalid[e] = 0; ent_pf[e] = 0;
              ent_dist[e] = 1; ent_bexp[e] = 0; ent_buntil[e] = 0;
              det_on[d] = 0;
              return;
            end
          end
        end
        det_cnt2[d]++;
      end
    end
  endfunction

  function automatic void detector_feed(int e, logic [63:0] idx, logic [63:0] now);
    int found;
    logic [63:0] wait_cycles;
    found = -1;
    if (ent_ind[e] || now < ent_buntil[e]) return;
    for (int d = 0; d < DET_N; d++)
      if (det_on[d] && det_ent[d] == 4'(e)) begin
        found = d;
        break;
      end
    if (found < 0) begin
      for (int d = 0; d < DET_N; d++)
        if (!det_on[d]) begin
          clear_detector(d);
          det_on[d] = 1;
          det_ent[d] = 4'(e);
          det_idx1[d] = idx;
          return;
        end
    end else if (!det_two[found]) begin
      det_idx2[found] = idx;
      det_two[found] = 1;
      det_cnt2[found] = 0;
    end else begin
      wait_cycles = 64'd1 << ent_bexp[e];
      det_on[found] = 0;
      if (ent_bexp[e] < bo_cap) ent_bexp[e]++;
      ent_buntil[e] = now + wait_cycles * {48'd0, bo_unit};
    end
  endfunction

  function automatic void predict_prefetches(logic op, logic [63:0] addr, logic [63:0] pc,
                                             logic hit, logic [63:0] now,
                                             logic [63:0] data, logic [3:0] rep);
    logic [63:0] idx, a, ns, target, lim, md;
    logic [1:0]  sc;
    int e, v;
    e = -1;
    burst_q.delete();
    if (op == OP_REPLY) begin
      if (ent_valid[rep] && ent_ind[rep]) begin
        idx = trim_index(data, elem_size(ent_stride[rep]));
        a = shift_index(idx, ent_shift[rep]) + ent_base[rep];
        if (addr_good(a)) add_result(KIND_INDIRECT, a, 2'd0, 4'd0);
      end
    end else begin
      for (int i = 0; i < TBL_N; i++) begin
        if (!ent_valid[i] || !ent_ind[i] || ent_pf[i] || !ent_pvalid[i]) continue;
        target = shift_index(ent_pidx[i], ent_shift[i]) + ent_base[i];
        if (addr[63:LINE_BITS] == target[63:LINE_BITS]) begin
          if (ent_iconf[i] < CONF_MAX) ent_iconf[i]++;
          ent_pvalid[i] = 0;
          if (ent_iconf[i] >= ind_thr) ent_pf[i] = 1;
        end
      end
      for (int i = 0; i < TBL_N; i++)
        if (ent_valid[i] && ent_pc[i] == pc) begin
          e = i;
          break;
        end
      if (e >= 0) begin
        ns = addr - ent_last[e];
        if (ns != 0) begin
          if (ns == ent_stride[e] && ent_conf[e] >= 1) begin
            if (ent_conf[e] < CONF_MAX) ent_conf[e]++;
          end else if (ent_conf[e] <= 1) begin
            ent_stride[e] = ns; ent_conf[e] = 1;
          end else if (ent_ind[e]) begin
            ent_stride[e] = ns; ent_conf[e] = 1; ent_dist[e] = 1;
          end else begin
            ent_conf[e]--; ent_stride[e] = ns;
          end
          ent_last[e] = addr;
          ent_used[e] = now;
          if (ent_conf[e] >= spf_thr) begin
            lim = stream_dist > 4 ? 4 : stream_dist;
            for (logic [63:0] d = 1; d <= lim; d++) begin
              a = addr + ent_stride[e] * d;
              if (addr_good(a)) add_result(KIND_STREAM, a, 2'd0, 4'd0);
            end
          end
          if (ent_conf[e] >= feed_thr) begin
            sc = elem_size(ent_stride[e]);
            idx = trim_index(data, sc);
            if (ent_ind[e] && ent_pf[e]) begin
              md = max_dist;
              if (md < 1) md = 1;
              if (md > 16) md = 16;
              for (logic [63:0] d = 1; d <= ent_dist[e] && d <= 16; d++) begin
                a = addr + ent_stride[e] * d;
                if (addr_good(a)) add_result(KIND_INDEX, a, sc, 4'(e));
              end
              if (ent_dist[e] < md) ent_dist[e]++;
            end else if (ent_ind[e]) begin
              if (ent_pvalid[e] && ent_iconf[e] > 0) ent_iconf[e]--;
              ent_pidx[e] = idx;
              ent_pvalid[e] = 1;
            end else begin
              detector_feed(e, idx, now);
            end
          end
        end else begin
          ent_used[e] = now;
        end
      end else begin
        v = pick_victim();
        for (int i = 0; i < DET_N; i++)
          if (det_on[i] && det_ent[i] == 4'(v)) det_on[i] = 0;
        clear_entry(v);
        ent_valid[v] = 1;
        ent_pc[v] = pc;
        ent_last[v] = addr;
        ent_used[v] = now;
      end
      if (!hit) detector_miss(addr);
    end
    if (burst_q.size() > 0) burst_q[burst_q.size() - 1].last = 1'b1;
    foreach (burst_q[i]) expected_q.push_back(burst_q[i]);
  endfunction

  function automatic void write_register(logic [2:0] index, logic [15:0] value);
    case (index)
      CFG_FEED_THR:   feed_thr = value[2:0];
      CFG_SPF_THR:    spf_thr = value[2:0];
      CFG_IND_THR:    ind_thr = value[2:0];
      CFG_MAX_DIST:   max_dist = value[4:0];
      CFG_STREAM_DST: stream_dist = value[2:0];
      CFG_BO_UNIT:    bo_unit = value;
      CFG_BO_CAP:     bo_cap = value[3:0];
      default: ;
    endcase
  endfunction

  function automatic void compare_result();
    pf_result_t want, got;
    got.kind = m_axis_tuser;
    got.addr = m_axis_tdata[39:0];
    got.size = m_axis_tdata[41:40];
    got.tag  = m_axis_tdata[45:42];
    got.last = m_axis_tlast;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result kind %0d addr %h size %0d tag %0d last %0b",
                 $realtime, got.kind, got.addr, got.size, got.tag, got.last);
      return;
    end
    want = expected_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result mismatch, expected kind %0d addr %h size %0d tag %0d last %0b, got kind %0d addr %h size %0d tag %0d last %0b",
                 $realtime, want.kind, want.addr, want.size, want.tag, want.last,
                 got.kind, got.addr, got.size, got.tag, got.last);
    end
  endfunction

  initial begin
    mismatches = 0;
    reset_prefetcher();
  end

  always @(posedge clk) begin
    if (rst) begin
      reset_prefetcher();
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        predict_prefetches(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[127:64],
                           s_axis_tdata[128], s_axis_tdata[192:129],
                           s_axis_tdata[256:193], s_axis_tdata[260:257]);
      if (m_axis_tvalid && m_axis_tready) compare_result();
    end
    outstanding <= expected_q.size();
    fail_count <= mismatches;
  end

endmodule

// ===== tb/tb_indirect_memory_prefetcher.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indirect memory prefetcher testbench
// Drives directed corner accesses, then index-array streams paired with
// indirect target misses, index replies and random noise under several
// register settings, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_indirect_memory_prefetcher;
  import imp_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [263:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [47:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  int          outstanding;
  int          fail_count;
  int          idle_cycles = 0;
  bit          steady = 0;
  logic [63:0] stamp = 64'd1000;

  always #6 clk = ~clk;

  indirect_memory_prefetcher u_dut (.*);

  imp_result_checker u_checker (.*);

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 0;
    else m_axis_tready <= steady || ($urandom_range(0, 99) >= 28);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(logic op, logic [63:0] a, logic [63:0] p, logic h,
                           logic [63:0] n, logic [63:0] d, logic [3:0] r);
    if (!steady && $urandom_range(0, 99) < 28) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {3'd0, r, d, n, h, p, a};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_access(logic [63:0] a, logic [63:0] p, logic h, logic [63:0] d);
    send_item(OP_ACCESS, a, p, h, stamp, d, 4'd0);
    stamp += $urandom_range(1, 50);
  endtask

  task automatic send_reply(logic [3:0] r, logic [63:0] d);
    send_item(OP_REPLY, {$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(0, 1),
              stamp, d, r);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, logic [15:0] value);
    cfg_valid <= 1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_registers(int ft, int st, int it, int md, int sd, int bu, int bc);
    write_reg(CFG_FEED_THR, 16'(ft));
    write_reg(CFG_SPF_THR, 16'(st));
    write_reg(CFG_IND_THR, 16'(it));
    write_reg(CFG_MAX_DIST, 16'(md));
    write_reg(CFG_STREAM_DST, 16'(sd));
    write_reg(CFG_BO_UNIT, 16'(bu));
    write_reg(CFG_BO_CAP, 16'(bc));
  endtask

  task automatic index_stream(int steps);
    logic [63:0] stride, b_addr, a_base, idx, target, pc_b, pc_a;
    logic [1:0]  sh;
    int          off;
    case ($urandom_range(0, 6))
      0: stride = 1;
      1: stride = 2;
      2: stride = 4;
      3: stride = 8;
      4: stride = -64'd4;
      5: stride = -64'd8;
      default: stride = 12;
    endcase
    b_addr = {24'd0, 8'($urandom_range(1, 255)), 32'($urandom)};
    a_base = {24'd0, 8'($urandom_range(1, 255)), 32'($urandom)} & ~64'h3f;
    sh = 2'($urandom_range(0, 3));
    off = $urandom_range(0, 7);
    pc_b = {$urandom, $urandom};
    pc_a = {$urandom, $urandom};
    for (int i = 0; i < steps; i++) begin
      idx = (stride == 1 || stride == -64'd1) ? $urandom_range(0, 255)
                                                : $urandom_range(0, 4095);
      case (sh)
        2'd0: target = idx << 2;
        2'd1: target = idx << 3;
        2'd2: target = idx << 4;
        default: target = idx >> 3;
      endcase
      target += a_base + off;
      send_access(b_addr, pc_b, $urandom_range(0, 1), idx);
      b_addr += stride;
      if ($urandom_range(0, 99) < 85)
        send_access(target, pc_a, $urandom_range(0, 9) == 0, {$urandom, $urandom});
      if ($urandom_range(0, 99) < 30)
        send_reply(4'($urandom_range(0, 15)), $urandom_range(0, 4095));
    end
  endtask

  task automatic noise(int count);
    for (int i = 0; i < count; i++)
      send_item($urandom_range(0, 1), {$urandom, $urandom}, {$urandom, $urandom},
                $urandom_range(0, 1), {$urandom, $urandom}, {$urandom, $urandom},
                4'($urandom_range(0, 15)));
  endtask

  task automatic run_phase();
    for (int p = 0; p < 3; p++) begin
      index_stream($urandom_range(3, 6));
      if (p == 1) drain();
      noise(3);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_reply(4'd0, 64'd5);
    send_reply(4'd15, '1);
    send_item(OP_ACCESS, 64'd0, 64'd0, 1'b0, 64'd0, 64'd0, 4'd0);
    send_item(OP_ACCESS, '1, '1, 1'b1, '1, '1, 4'd15);
    for (int i = 0; i < 6; i++)
      send_access(64'h28 - 64'(8 * i), 64'h77, 1'b0, 64'(i));
    for (int i = 0; i < 6; i++)
      send_access(64'hff_ffff_ff00 + 64'(64 * i), 64'h99, 1'b1, 64'(i + 3));
    index_stream(6);

    drain();
    set_registers(1, 1, 1, 1, 1, 1, 0);
    run_phase();
    drain();
    set_registers(7, 7, 7, 16, 4, 65535, 15);
    run_phase();
    drain();
    set_registers(0, 0, 0, 31, 7, 3, 2);
    run_phase();
    drain();
    set_registers(2, 3, 2, 8, 2, 20, 4);
    steady = 1;
    run_phase();
    steady = 0;
    run_phase();

    drain();
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
